// ===== hw/rtl/cosine_similarity_engine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Cosine similarity engine assertion macros
// Shorthand for clocked implication checks with active-low reset masking.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_ENGINE_UNIT_MACROS_SVH
`define COSINE_SIMILARITY_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define CSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cse check failed");

// next-cycle implication
`define CSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cse check failed");

`endif

// ===== hw/rtl/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity engine package
// Beat types and datapath widths shared across the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cse_pkg;

  localparam int ELEM_W      = 16;   // Q4.12 element
  localparam int PROD_W      = 32;   // element product
  localparam int SUM_W       = 48;   // running sums, Q24.24
  localparam int COS_W       = 16;   // Q1.14 result
  localparam int DP_W        = 128;  // shared add/sub datapath
  localparam int QW          = 32;   // quotient width
  localparam int ROOT_W      = 16;   // integer root of the quotient
  localparam int T_SHIFT     = 30;   // dot^2 scaled by 2^30
  localparam int CNT_W       = 6;
  localparam int SQRT_STEPS  = 16;
  localparam int SQ_CNT_W    = 4;

  localparam logic [COS_W-1:0] ONE_Q14 = 16'd16384;

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     is_last;
  } cse_in_t;

  typedef struct packed {
    logic signed [COS_W-1:0] cosine;
    logic                    zero_norm;
  } cse_out_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] dot;
    logic        [SUM_W-1:0] norm_a;
    logic        [SUM_W-1:0] norm_b;
  } cse_sums_t;

endpackage

// ===== hw/rtl/cse_alu.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity engine shared adder
// One wide add/subtract with a compare flag (a >= b on subtract).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_alu (
  input  logic [cse_pkg::DP_W-1:0] a_i,
  input  logic [cse_pkg::DP_W-1:0] b_i,
  input  logic                     sub_i,
  output logic [cse_pkg::DP_W-1:0] sum_o,
  output logic                     ge_o
);
  import cse_pkg::*;

  logic [DP_W:0] full;
  logic [DP_W-1:0] b_op;

  assign b_op = sub_i ? ~b_i : b_i;
  assign full = {1'b0, a_i} + {1'b0, b_op} + {{DP_W{1'b0}}, sub_i};
  assign sum_o = full[DP_W-1:0];
  assign ge_o  = full[DP_W];  // no borrow

endmodule

// ===== hw/rtl/cse_acc.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity engine accumulator
// Registers the three element products, then adds them into saturating sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_acc (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept_i,
  input  cse_pkg::cse_in_t   item_i,
  output logic               start_o,
  output cse_pkg::cse_sums_t sums_o
);
  import cse_pkg::*;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [PROD_W-1:0] p);
    logic [SUM_W:0] r;
    begin
      r = {s[SUM_W-1], s} + {{(SUM_W+1-PROD_W){p[PROD_W-1]}}, p};
      if (r[SUM_W] != r[SUM_W-1]) begin
        sat_add = r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sat_add = r[SUM_W-1:0];
      end
    end
  endfunction

  logic                     p_vld_r, p_vld_nxt;
  logic                     p_last_r;
  logic signed [PROD_W-1:0] p_ab_r, p_aa_r, p_bb_r;
  logic        [SUM_W-1:0]  dot_r, na_r, nb_r;
  logic        [SUM_W-1:0]  dot_nxt, na_nxt, nb_nxt;
  logic        [SUM_W-1:0]  dot_add, na_add, nb_add;

  assign p_vld_nxt = accept_i;

  assign dot_add = sat_add(dot_r, p_ab_r);
  assign na_add  = sat_add(na_r, p_aa_r);
  assign nb_add  = sat_add(nb_r, p_bb_r);

  assign start_o       = p_vld_r & p_last_r;
  assign sums_o.dot    = dot_add;
  assign sums_o.norm_a = na_add;
  assign sums_o.norm_b = nb_add;

  always_comb begin
    dot_nxt = dot_r;
    na_nxt  = na_r;
    nb_nxt  = nb_r;
    if (p_vld_r) begin
      if (p_last_r) begin
        dot_nxt = '0;
        na_nxt  = '0;
        nb_nxt  = '0;
      end else begin
        dot_nxt = dot_add;
        na_nxt  = na_add;
        nb_nxt  = nb_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      dot_r   <= '0;
      na_r    <= '0;
      nb_r    <= '0;
    end else begin
      p_vld_r <= p_vld_nxt;
      dot_r   <= dot_nxt;
      na_r    <= na_nxt;
      nb_r    <= nb_nxt;
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (accept_i) begin
      p_last_r <= item_i.is_last;
      p_ab_r   <= item_i.elem_a * item_i.elem_b;
      p_aa_r   <= item_i.elem_a * item_i.elem_a;
      p_bb_r   <= item_i.elem_b * item_i.elem_b;
    end
  end

endmodule

// ===== hw/rtl/cse_solver.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity engine solver
// Sequencer around the shared adder: na*nb and dot^2 by shift-add, restoring
// divide, restoring square root, then rounding and sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_solver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  cse_pkg::cse_sums_t sums_i,
  output logic               done_o,
  output cse_pkg::cse_out_t  res_o
);
  import cse_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MULP = 3'd1;
  localparam logic [2:0] ST_MULT = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DP_W-1:0]  x_r, x_nxt;   // product P, then divisor, then root
  logic [DP_W-1:0]  y_r, y_nxt;   // dot^2, then remainder
  logic [QW-1:0]    q_r, q_nxt;   // quotient, then sqrt radicand
  logic [SUM_W-1:0] mq_r, mq_nxt; // multiplier shift register
  logic [SUM_W-1:0] na_r, na_nxt;
  logic [SUM_W-1:0] mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  cse_out_t         res_r, res_nxt;

  logic [DP_W-1:0]   alu_a, alu_b, alu_sum;
  logic              alu_sub, alu_ge;
  logic [DP_W-1:0]   sqrt_bit, sqrt_res;
  logic [QW-1:0]     q_shift;
  logic [ROOT_W:0]   root_inc;
  logic [COS_W-1:0]  round_mag, clamp_mag;

  cse_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .ge_o  (alu_ge)
  );

  assign sqrt_bit = {{(DP_W-1){1'b0}}, 1'b1} << {cnt_r[SQ_CNT_W-1:0], 1'b0};
  assign sqrt_res = alu_ge ? ((x_r >> 1) | sqrt_bit) : (x_r >> 1);
  assign q_shift  = {q_r[QW-2:0], alu_ge};

  // m = (root + 1) / 2, clamped to one
  assign root_inc  = {1'b0, sqrt_res[ROOT_W-1:0]} + {{ROOT_W{1'b0}}, 1'b1};
  assign round_mag = root_inc[ROOT_W:1];
  assign clamp_mag = (round_mag > ONE_Q14) ? ONE_Q14 : round_mag;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    q_nxt     = q_r;
    mq_nxt    = mq_r;
    na_nxt    = na_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          neg_nxt = sums_i.dot[SUM_W-1];
          mag_nxt = sums_i.dot[SUM_W-1] ? (~sums_i.dot + 1'b1) : sums_i.dot;
          na_nxt  = sums_i.norm_a;
          mq_nxt  = sums_i.norm_b;
          x_nxt   = '0;
          y_nxt   = '0;
          cnt_nxt = CNT_W'(SUM_W - 1);
          if (sums_i.norm_a == '0 || sums_i.norm_b == '0) begin
            res_nxt.cosine    = '0;
            res_nxt.zero_norm = 1'b1;
            state_nxt         = ST_DONE;
          end else begin
            state_nxt = ST_MULP;
          end
        end
      end
      ST_MULP: begin
        alu_a  = x_r << 1;
        alu_b  = mq_r[SUM_W-1] ? {{(DP_W-SUM_W){1'b0}}, na_r} : '0;
        x_nxt  = alu_sum;
        mq_nxt = mq_r << 1;
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(SUM_W - 1);
          mq_nxt    = mag_r;
          state_nxt = ST_MULT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_MULT: begin
        alu_a  = y_r << 1;
        alu_b  = mq_r[SUM_W-1] ? {{(DP_W-SUM_W){1'b0}}, mag_r} : '0;
        y_nxt  = alu_sum;
        mq_nxt = mq_r << 1;
        if (cnt_r == '0) begin
          y_nxt     = alu_sum << T_SHIFT;
          x_nxt     = x_r << (QW - 1);
          q_nxt     = '0;
          cnt_nxt   = CNT_W'(QW - 1);
          state_nxt = ST_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DIV: begin
        alu_a   = y_r;
        alu_b   = x_r;
        alu_sub = 1'b1;
        if (alu_ge) begin
          y_nxt = alu_sum;
        end
        q_nxt = q_shift;
        x_nxt = x_r >> 1;
        if (cnt_r == '0) begin
          if (q_shift[QW-1]) begin
            // quotient past 2^31: magnitude clamps to one
            res_nxt.cosine    = neg_r ? (~ONE_Q14 + 1'b1) : ONE_Q14;
            res_nxt.zero_norm = 1'b0;
            state_nxt         = ST_DONE;
          end else begin
            x_nxt     = '0;
            cnt_nxt   = CNT_W'(SQRT_STEPS - 1);
            state_nxt = ST_SQRT;
          end
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_SQRT: begin
        alu_a   = {{(DP_W-QW){1'b0}}, q_r};
        alu_b   = x_r | sqrt_bit;
        alu_sub = 1'b1;
        if (alu_ge) begin
          q_nxt = alu_sum[QW-1:0];
        end
        x_nxt = sqrt_res;
        if (cnt_r == '0) begin
          res_nxt.cosine    = neg_r ? (~clamp_mag + 1'b1) : clamp_mag;
          res_nxt.zero_norm = 1'b0;
          state_nxt         = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    q_r   <= q_nxt;
    mq_r  <= mq_nxt;
    na_r  <= na_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done_o = (state_r == ST_DONE);
  assign res_o  = res_r;

endmodule

// ===== hw/rtl/cosine_similarity_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity engine
// Streams element pairs of two vectors (Q4.12) and returns their cosine
// similarity in Q1.14 after the beat flagged is_last.
//
// Input: a beat is taken on a rising edge with start high and busy low.
// Beats without is_last are taken one per cycle; busy stays low for them.
// A beat with is_last raises busy until its result has gone out.
// Output: out_valid is high for exactly one cycle with out_data; the
// receiver cannot hold it off, and busy drops at the same edge.
// From the last beat to the result, the beat passes a product stage,
// 48 + 48 shift-add steps for na*nb and dot^2, 32 divide steps,
// 16 square-root steps and an output state, all through one
// 128-bit add/subtract unit. When the quotient passes 2^31 the
// square root is skipped (magnitude clamps to one), and when a norm
// is zero the result follows the sums directly (cosine 0, zero_norm 1).
// The first beat of the next vector can go in once busy has dropped.
// Sums saturate at the signed 48-bit range and clear after each last beat.
// Reset (rst_n low, synchronous) clears the sums and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cosine_similarity_engine_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cse_pkg::cse_in_t  in_data,
  output logic              out_valid,
  output cse_pkg::cse_out_t out_data
);
  import cse_pkg::*;

  logic      accept;
  logic      busy_r, busy_nxt;
  logic      solve_start;
  cse_sums_t sums;
  logic      done;
  cse_out_t  res;

  assign accept = start & ~busy_r;

  // busy covers the last beat through its result strobe
  always_comb begin
    busy_nxt = busy_r;
    if (accept && in_data.is_last) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  cse_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .item_i   (in_data),
    .start_o  (solve_start),
    .sums_o   (sums)
  );

  cse_solver u_solver (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (solve_start),
    .sums_i  (sums),
    .done_o  (done),
    .res_o   (res)
  );

  assign busy      = busy_r;
  assign out_valid = done;
  assign out_data  = res;

endmodule

// ===== hw/rtl/cse_checker.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity engine port checker
// Port-level timing checks, bound onto the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cosine_similarity_engine_unit_macros.svh"

module cse_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input cse_pkg::cse_in_t  in_data,
  input logic              out_valid,
  input cse_pkg::cse_out_t out_data
);
  import cse_pkg::*;

  // a last beat locks the input until its result
  `CSE_ASSERT_NEXT(a_last_busy, clk, rst_n, start && !busy && in_data.is_last, busy)

  // a result only ends a busy period, and frees the input
  `CSE_ASSERT_SAME(a_out_in_busy, clk, rst_n, out_valid, busy)
  `CSE_ASSERT_NEXT(a_out_frees, clk, rst_n, out_valid, !busy && !out_valid)

  // zero norm forces a zero cosine
  `CSE_ASSERT_SAME(a_zero_norm, clk, rst_n, out_valid && out_data.zero_norm, out_data.cosine == '0)

endmodule

bind cosine_similarity_engine_unit cse_checker u_cse_checker (.*);
